// ----- rtl/cia_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cia_pkg
// Shared types, codes and helper functions of the NA-aware integer column ALU.
// ----------------------------------------------------------------------------
package cia_pkg;

  localparam int unsigned DataW           = 64;
  localparam int unsigned MaxWidthDefault = 64;
  localparam int unsigned DivBits         = 2;
  localparam int unsigned DivStages       = DataW / DivBits;
  localparam int unsigned CfgIdxW         = 3;
  localparam int unsigned TypeW           = 3;
  localparam int unsigned OpW             = 4;
  localparam int unsigned ModeW           = 2;

  typedef enum logic [OpW-1:0] {
    OP_ADD      = 4'd0,
    OP_SUB      = 4'd1,
    OP_MUL      = 4'd2,
    OP_FLOORDIV = 4'd3,
    OP_MOD      = 4'd4,
    OP_EQ       = 4'd5,
    OP_NE       = 4'd6,
    OP_GT       = 4'd7,
    OP_LT       = 4'd8,
    OP_GE       = 4'd9,
    OP_LE       = 4'd10,
    OP_AND      = 4'd11,
    OP_OR       = 4'd12
  } op_e;

  typedef enum logic [TypeW-1:0] {
    TY_BOOL  = 3'd0,
    TY_INT8  = 3'd1,
    TY_INT16 = 3'd2,
    TY_INT32 = 3'd3,
    TY_INT64 = 3'd4
  } type_e;

  typedef enum logic [ModeW-1:0] {
    BC_NONE  = 2'd0,
    BC_RIGHT = 2'd1,
    BC_LEFT  = 2'd2
  } mode_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_OP     = 3'd0,
    CFG_LTYPE  = 3'd1,
    CFG_RTYPE  = 3'd2,
    CFG_MODE   = 3'd3,
    CFG_SCALAR = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [OpW-1:0]   op;
    logic [TypeW-1:0] ltype;
    logic [TypeW-1:0] rtype;
    logic [ModeW-1:0] mode;
    logic [DataW-1:0] scalar;
  } cfg_t;

  // operands after narrowing
  typedef struct packed {
    logic [DataW-1:0] x;
    logic [DataW-1:0] y;
    logic             xna;
    logic             yna;
    logic [OpW-1:0]   op;
    logic [TypeW-1:0] vcode;
    logic             err;
  } opnd_t;

  // everything that travels beside the divider
  typedef struct packed {
    logic [OpW-1:0]   op;
    logic [TypeW-1:0] vcode;
    logic [TypeW-1:0] rtype;
    logic             err;
    logic             na;
    logic [DataW-1:0] simple;
    logic [DataW-1:0] p0;
    logic [31:0]      p1;
    logic [31:0]      p2;
    logic             xneg;
    logic             yneg;
    logic [DataW-1:0] y;
  } side_t;

  typedef struct packed {
    logic [DataW-1:0] rem;
    logic [DataW-1:0] dvd;
    logic [DataW-1:0] dsr;
  } div_t;

  function automatic logic [6:0] type_width(logic [TypeW-1:0] code);
    case (code)
      TY_BOOL, TY_INT8: type_width = 7'd8;
      TY_INT16:         type_width = 7'd16;
      TY_INT32:         type_width = 7'd32;
      default:          type_width = 7'd64;
    endcase
  endfunction

  function automatic logic [DataW-1:0] narrow(logic [DataW-1:0] v, logic [TypeW-1:0] code);
    case (code)
      TY_BOOL, TY_INT8: narrow = {{56{v[7]}}, v[7:0]};
      TY_INT16:         narrow = {{48{v[15]}}, v[15:0]};
      TY_INT32:         narrow = {{32{v[31]}}, v[31:0]};
      default:          narrow = v;
    endcase
  endfunction

  function automatic logic [DataW-1:0] na_value(logic [TypeW-1:0] code);
    case (code)
      TY_BOOL, TY_INT8: na_value = 64'hFFFF_FFFF_FFFF_FF80;
      TY_INT16:         na_value = 64'hFFFF_FFFF_FFFF_8000;
      TY_INT32:         na_value = 64'hFFFF_FFFF_8000_0000;
      default:          na_value = 64'h8000_0000_0000_0000;
    endcase
  endfunction

endpackage

// ----- rtl/cia_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cia_front
// Operand selection, narrowing to type width, NA detection and error decode.
// ----------------------------------------------------------------------------
module cia_front #(
  parameter int unsigned MAX_WIDTH = cia_pkg::MaxWidthDefault
) (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  cia_pkg::cfg_t             cfg_i,
  input  logic [cia_pkg::DataW-1:0] left_i,
  input  logic [cia_pkg::DataW-1:0] right_i,
  output cia_pkg::opnd_t            opnd_o
);

  cia_pkg::opnd_t              opnd_d, opnd_q;
  logic [cia_pkg::DataW-1:0]   lraw, rraw;
  logic [cia_pkg::TypeW-1:0]   vmax;

  always_comb begin
    lraw = (cfg_i.mode == cia_pkg::BC_LEFT)  ? cfg_i.scalar : left_i;
    rraw = (cfg_i.mode == cia_pkg::BC_RIGHT) ? cfg_i.scalar : right_i;
    vmax = (cfg_i.ltype > cfg_i.rtype) ? cfg_i.ltype : cfg_i.rtype;

    opnd_d.x     = cia_pkg::narrow(lraw, cfg_i.ltype);
    opnd_d.y     = cia_pkg::narrow(rraw, cfg_i.rtype);
    opnd_d.xna   = (opnd_d.x == cia_pkg::na_value(cfg_i.ltype));
    opnd_d.yna   = (opnd_d.y == cia_pkg::na_value(cfg_i.rtype));
    opnd_d.op    = cfg_i.op;
    // bool with bool counts as int8 for arithmetic
    opnd_d.vcode = (vmax == cia_pkg::TY_BOOL) ? cia_pkg::TY_INT8 : vmax;
    opnd_d.err   = (cfg_i.op > cia_pkg::OP_OR) ||
                   (cfg_i.ltype > cia_pkg::TY_INT64) ||
                   (cfg_i.rtype > cia_pkg::TY_INT64) ||
                   (cfg_i.mode > cia_pkg::BC_LEFT) ||
                   (int'(cia_pkg::type_width(cfg_i.ltype)) > MAX_WIDTH) ||
                   (int'(cia_pkg::type_width(cfg_i.rtype)) > MAX_WIDTH) ||
                   ((cfg_i.op >= cia_pkg::OP_AND) &&
                    ((cfg_i.ltype != cia_pkg::TY_BOOL) ||
                     (cfg_i.rtype != cia_pkg::TY_BOOL)));
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      opnd_q <= opnd_d;
    end
  end

  assign opnd_o = opnd_q;

endmodule

// ----- rtl/cia_prep.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cia_prep
// Add, subtract, compare and logic results, multiplier partial products and
// divider setup.
// ----------------------------------------------------------------------------
module cia_prep (
  input  logic           clk_i,
  input  logic           en_i,
  input  cia_pkg::opnd_t opnd_i,
  output cia_pkg::side_t side_o,
  output cia_pkg::div_t  div_o
);

  cia_pkg::side_t side_d, side_q;
  cia_pkg::div_t  div_d, div_q;
  logic           both, nn, eq, lt, v;

  always_comb begin
    both = !opnd_i.xna && !opnd_i.yna;
    nn   = opnd_i.xna && opnd_i.yna;
    eq   = (opnd_i.x == opnd_i.y);
    lt   = ($signed(opnd_i.x) < $signed(opnd_i.y));
    v    = 1'b0;
    side_d.simple = '0;
    case (opnd_i.op)
      cia_pkg::OP_ADD: side_d.simple = opnd_i.x + opnd_i.y;
      cia_pkg::OP_SUB: side_d.simple = opnd_i.x - opnd_i.y;
      cia_pkg::OP_EQ:  v = (both && eq) || nn;
      cia_pkg::OP_NE:  v = (!both || !eq) && !nn;
      cia_pkg::OP_GT:  v = both && !lt && !eq;
      cia_pkg::OP_LT:  v = both && lt;
      cia_pkg::OP_GE:  v = (both && !lt) || nn;
      cia_pkg::OP_LE:  v = (both && (lt || eq)) || nn;
      default:         v = 1'b0;
    endcase
    if (opnd_i.op >= cia_pkg::OP_EQ && opnd_i.op <= cia_pkg::OP_LE) begin
      side_d.simple = {63'd0, v};
    end else if (opnd_i.op == cia_pkg::OP_AND || opnd_i.op == cia_pkg::OP_OR) begin
      if (!both) begin
        side_d.simple = cia_pkg::na_value(cia_pkg::TY_BOOL);
      end else if (opnd_i.op == cia_pkg::OP_AND) begin
        side_d.simple = {63'd0, (opnd_i.x != '0) && (opnd_i.y != '0)};
      end else begin
        side_d.simple = {63'd0, (opnd_i.x != '0) || (opnd_i.y != '0)};
      end
    end

    side_d.op    = opnd_i.op;
    side_d.vcode = opnd_i.vcode;
    side_d.rtype = (opnd_i.op <= cia_pkg::OP_MOD) ? opnd_i.vcode : cia_pkg::TY_BOOL;
    side_d.err   = opnd_i.err;
    side_d.na    = !both ||
                   ((opnd_i.op == cia_pkg::OP_FLOORDIV || opnd_i.op == cia_pkg::OP_MOD) &&
                    (opnd_i.y == '0));
    // low 64 bits of the product from three 32x32 partial products
    side_d.p0    = {32'd0, opnd_i.x[31:0]} * {32'd0, opnd_i.y[31:0]};
    side_d.p1    = opnd_i.x[31:0] * opnd_i.y[63:32];
    side_d.p2    = opnd_i.x[63:32] * opnd_i.y[31:0];
    side_d.xneg  = opnd_i.x[63];
    side_d.yneg  = opnd_i.y[63];
    side_d.y     = opnd_i.y;

    div_d.rem = '0;
    div_d.dvd = opnd_i.x[63] ? -opnd_i.x : opnd_i.x;
    div_d.dsr = opnd_i.y[63] ? -opnd_i.y : opnd_i.y;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q <= side_d;
      div_q  <= div_d;
    end
  end

  assign side_o = side_q;
  assign div_o  = div_q;

endmodule

// ----- rtl/cia_divider.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cia_divider
// Pipelined unsigned restoring divider, DivBits quotient bits per stage, with
// the side payload carried alongside.
// ----------------------------------------------------------------------------
module cia_divider (
  input  logic                          clk_i,
  input  logic [cia_pkg::DivStages-1:0] en_i,
  input  cia_pkg::side_t                side_i,
  input  cia_pkg::div_t                 div_i,
  output cia_pkg::side_t                side_o,
  output cia_pkg::div_t                 div_o
);

  cia_pkg::side_t side_q [cia_pkg::DivStages];
  cia_pkg::div_t  div_q  [cia_pkg::DivStages];

  for (genvar k = 0; k < cia_pkg::DivStages; k++) begin : g_stage
    cia_pkg::side_t side_in;
    cia_pkg::div_t  div_in, div_d;
    logic [cia_pkg::DataW:0] t;
    logic                    qb;

    if (k == 0) begin : g_first
      assign side_in = side_i;
      assign div_in  = div_i;
    end else begin : g_next
      assign side_in = side_q[k-1];
      assign div_in  = div_q[k-1];
    end

    always_comb begin
      div_d = div_in;
      t     = '0;
      qb    = 1'b0;
      for (int i = 0; i < cia_pkg::DivBits; i++) begin
        t  = {div_d.rem, div_d.dvd[cia_pkg::DataW-1]};
        qb = (t >= {1'b0, div_d.dsr});
        if (qb) begin
          t = t - {1'b0, div_d.dsr};
        end
        div_d.rem = t[cia_pkg::DataW-1:0];
        div_d.dvd = {div_d.dvd[cia_pkg::DataW-2:0], qb};
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i[k]) begin
        side_q[k] <= side_in;
        div_q[k]  <= div_d;
      end
    end
  end

  assign side_o = side_q[cia_pkg::DivStages-1];
  assign div_o  = div_q[cia_pkg::DivStages-1];

endmodule

// ----- rtl/cia_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cia_back
// Product sum, floor correction of quotient and remainder, NA and width
// formatting into the output register.
// ----------------------------------------------------------------------------
module cia_back (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  cia_pkg::side_t            side_i,
  input  cia_pkg::div_t             div_i,
  output logic [cia_pkg::DataW-1:0] result_o,
  output logic [cia_pkg::TypeW-1:0] rtype_o,
  output logic                      err_o
);

  logic [cia_pkg::DataW-1:0] res_d, res_q;
  logic [cia_pkg::TypeW-1:0] rtype_d, rtype_q;
  logic                      err_q;
  logic [cia_pkg::DataW-1:0] mul, quo, mtr, modv, val;
  logic [31:0]               mid;
  logic                      diff, fix;

  always_comb begin
    mid  = side_i.p1 + side_i.p2;
    mul  = side_i.p0 + {mid, 32'd0};
    diff = side_i.xneg ^ side_i.yneg;
    // floor rounding when signs differ and something is left over
    fix  = diff && (div_i.rem != '0);
    quo  = !diff ? div_i.dvd : (fix ? ~div_i.dvd : -div_i.dvd);
    mtr  = side_i.xneg ? -div_i.rem : div_i.rem;
    modv = fix ? mtr + side_i.y : mtr;
    case (side_i.op)
      cia_pkg::OP_MUL:      val = mul;
      cia_pkg::OP_FLOORDIV: val = quo;
      cia_pkg::OP_MOD:      val = modv;
      default:              val = side_i.simple;
    endcase

    if (side_i.err) begin
      res_d   = '0;
      rtype_d = cia_pkg::TY_BOOL;
    end else if (side_i.op <= cia_pkg::OP_MOD) begin
      res_d   = side_i.na ? cia_pkg::na_value(side_i.vcode)
                          : cia_pkg::narrow(val, side_i.vcode);
      rtype_d = side_i.rtype;
    end else begin
      res_d   = side_i.simple;
      rtype_d = side_i.rtype;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q   <= res_d;
      rtype_q <= rtype_d;
      err_q   <= side_i.err;
    end
  end

  assign result_o = res_q;
  assign rtype_o  = rtype_q;
  assign err_o    = err_q;

endmodule

// ----- rtl/na_aware_integer_column_alu.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// na_aware_integer_column_alu
// Element-wise integer/boolean column ALU with NA handling.
// ----------------------------------------------------------------------------
// pipeline: front, prep, divider and back registers, each with a valid bit
// throughput: one item per cycle unless m_axis_tready holds the pipe; each stage moves on when the next one frees
// reset: rst_ni clears valid bits and configuration (op add, types int64,
// no broadcast, scalar 0); data registers are not reset
module na_aware_integer_column_alu #(
  parameter int unsigned MAX_WIDTH = cia_pkg::MaxWidthDefault
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [127:0]                s_axis_tdata,  // left_value, right_value
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [63:0]                 m_axis_tdata,  // result
  output logic [3:0]                  m_axis_tuser,  // result_type, error
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [cia_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [63:0]                 cfg_data_i
);

  localparam int unsigned NumStages = cia_pkg::DivStages + 3;

  cia_pkg::cfg_t        cfg_q;
  logic [NumStages-1:0] vld_d, vld_q, en;
  cia_pkg::opnd_t       opnd;
  cia_pkg::side_t       side_p, side_v;
  cia_pkg::div_t        div_p, div_v;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.op     <= cia_pkg::OP_ADD;
      cfg_q.ltype  <= cia_pkg::TY_INT64;
      cfg_q.rtype  <= cia_pkg::TY_INT64;
      cfg_q.mode   <= cia_pkg::BC_NONE;
      cfg_q.scalar <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        cia_pkg::CFG_OP:     cfg_q.op     <= cfg_data_i[cia_pkg::OpW-1:0];
        cia_pkg::CFG_LTYPE:  cfg_q.ltype  <= cfg_data_i[cia_pkg::TypeW-1:0];
        cia_pkg::CFG_RTYPE:  cfg_q.rtype  <= cfg_data_i[cia_pkg::TypeW-1:0];
        cia_pkg::CFG_MODE:   cfg_q.mode   <= cfg_data_i[cia_pkg::ModeW-1:0];
        cia_pkg::CFG_SCALAR: cfg_q.scalar <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // a stage loads when it is empty or its content moves on
  always_comb begin
    en[NumStages-1] = !vld_q[NumStages-1] || m_axis_tready;
    for (int k = NumStages - 2; k >= 0; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
    vld_d = vld_q;
    if (en[0]) begin
      vld_d[0] = s_axis_tvalid;
    end
    for (int k = 1; k < NumStages; k++) begin
      if (en[k]) begin
        vld_d[k] = vld_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign s_axis_tready = en[0];
  assign m_axis_tvalid = vld_q[NumStages-1];

  cia_front #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_front (
    .clk_i  (clk_i),
    .en_i   (en[0]),
    .cfg_i  (cfg_q),
    .left_i (s_axis_tdata[63:0]),
    .right_i(s_axis_tdata[127:64]),
    .opnd_o (opnd)
  );

  cia_prep u_prep (
    .clk_i (clk_i),
    .en_i  (en[1]),
    .opnd_i(opnd),
    .side_o(side_p),
    .div_o (div_p)
  );

  cia_divider u_divider (
    .clk_i (clk_i),
    .en_i  (en[NumStages-2:2]),
    .side_i(side_p),
    .div_i (div_p),
    .side_o(side_v),
    .div_o (div_v)
  );

  cia_back u_back (
    .clk_i   (clk_i),
    .en_i    (en[NumStages-1]),
    .side_i  (side_v),
    .div_i   (div_v),
    .result_o(m_axis_tdata),
    .rtype_o (m_axis_tuser[2:0]),
    .err_o   (m_axis_tuser[3])
  );

endmodule

// ----- rtl/cia_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cia_checker
// Port-level checks of the column ALU, bound to the top level.
// ----------------------------------------------------------------------------
module cia_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        s_axis_tvalid,
  input logic                        s_axis_tready,
  input logic [127:0]                s_axis_tdata,
  input logic                        m_axis_tvalid,
  input logic                        m_axis_tready,
  input logic [63:0]                 m_axis_tdata,
  input logic [3:0]                  m_axis_tuser,
  input logic                        cfg_valid_i,
  input logic                        cfg_ready_o,
  input logic [cia_pkg::CfgIdxW-1:0] cfg_index_i,
  input logic [63:0]                 cfg_data_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("output item dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("output item changed while stalled");

  // an unsupported combination gives a zero result of type bool
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[3] |-> (m_axis_tdata == 64'd0) && (m_axis_tuser[2:0] == 3'd0))
    else $error("error item carries data");

  // bool results are false, true or the 8-bit NA
  a_bool_val: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[3] && (m_axis_tuser[2:0] == 3'd0) |->
      (m_axis_tdata == 64'd0) || (m_axis_tdata == 64'd1) ||
      (m_axis_tdata == 64'hFFFF_FFFF_FFFF_FF80))
    else $error("bool result out of range");

endmodule

bind na_aware_integer_column_alu cia_checker u_checker (.*);

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Streams operand pairs through the column ALU under a range of operation,
// type and broadcast settings, and checks every result against a predictor or a known expectation.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned Latency  = 40;
  localparam int unsigned CycleCap = 400000;

  typedef struct packed {
    logic [63:0] value;
    logic [2:0]  rtype;
    logic        err;
  } alu_out_t;

  typedef struct {
    logic [3:0]  op;
    logic [2:0]  lt;
    logic [2:0]  rt;
    logic [1:0]  mode;
    logic [63:0] a;
    logic [63:0] b;
    bit          known;
    alu_out_t    want;
  } vec_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [127:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;
  logic [3:0] m_axis_tuser;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [cia_pkg::CfgIdxW-1:0] cfg_index_i = cia_pkg::CFG_OP;
  logic [63:0] cfg_data_i = '0;

  na_aware_integer_column_alu u_dut (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  // shadow of the configuration
  logic [3:0]  sh_op = cia_pkg::OP_ADD;
  logic [2:0]  sh_lt = cia_pkg::TY_INT64;
  logic [2:0]  sh_rt = cia_pkg::TY_INT64;
  logic [1:0]  sh_mode = cia_pkg::BC_NONE;
  logic [63:0] sh_scalar = '0;

  alu_out_t pending_results[$];
  int mismatches = 0;
  int cycles = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic int unsigned width_of(logic [2:0] code);
    case (code)
      cia_pkg::TY_BOOL, cia_pkg::TY_INT8: return 8;
      cia_pkg::TY_INT16:                  return 16;
      cia_pkg::TY_INT32:                  return 32;
      default:                            return 64;
    endcase
  endfunction

  function automatic logic [63:0] sext_to(logic [63:0] v, int unsigned w);
    logic [63:0] r;
    r = v;
    for (int i = w; i < 64; i++) r[i] = v[w-1];
    return r;
  endfunction

  function automatic logic [63:0] min_of(int unsigned w);
    return sext_to(64'd1 << (w - 1), w);
  endfunction

  function automatic alu_out_t column_op(logic [63:0] a_raw, logic [63:0] b_raw);
    alu_out_t o;
    int unsigned lw, rw, vw;
    logic [63:0] x, y;
    logic [2:0] vcode;
    logic signed [63:0] sx, sy, q, m;
    bit xna, yna, both, v;
    o = '0;
    if (sh_op > cia_pkg::OP_OR || sh_lt > cia_pkg::TY_INT64 ||
        sh_rt > cia_pkg::TY_INT64 || sh_mode > cia_pkg::BC_LEFT ||
        (sh_op >= cia_pkg::OP_AND &&
         (sh_lt != cia_pkg::TY_BOOL || sh_rt != cia_pkg::TY_BOOL))) begin
      o.err = 1'b1;
      return o;
    end
    if (sh_mode == cia_pkg::BC_RIGHT) b_raw = sh_scalar;
    if (sh_mode == cia_pkg::BC_LEFT) a_raw = sh_scalar;
    lw = width_of(sh_lt);
    rw = width_of(sh_rt);
    x = sext_to(a_raw, lw);
    y = sext_to(b_raw, rw);
    xna = (x == min_of(lw));
    yna = (y == min_of(rw));
    sx = x;
    sy = y;
    vcode = (sh_lt > sh_rt) ? sh_lt : sh_rt;
    if (vcode == cia_pkg::TY_BOOL) vcode = cia_pkg::TY_INT8;
    vw = width_of(vcode);
    o.rtype = vcode;
    both = !xna && !yna;
    case (sh_op)
      cia_pkg::OP_ADD, cia_pkg::OP_SUB, cia_pkg::OP_MUL, cia_pkg::OP_FLOORDIV,
      cia_pkg::OP_MOD: begin
        if (xna || yna || (sh_op >= cia_pkg::OP_FLOORDIV && y == 0)) o.value = min_of(vw);
        else if (sh_op == cia_pkg::OP_ADD) o.value = sext_to(x + y, vw);
        else if (sh_op == cia_pkg::OP_SUB) o.value = sext_to(x - y, vw);
        else if (sh_op == cia_pkg::OP_MUL) o.value = sext_to(x * y, vw);
        else if (sx == min_of(64) && sy == -64'sd1) begin
          // overflowing quotient wraps, remainder is zero
          o.value = (sh_op == cia_pkg::OP_FLOORDIV) ? sext_to(x, vw) : '0;
        end else if (sh_op == cia_pkg::OP_FLOORDIV) begin
          q = sx / sy;
          if (((sx < 0) != (sy < 0)) && q * sy != sx) q = q - 1;
          o.value = sext_to(q, vw);
        end else begin
          m = sx % sy;
          if (((sx < 0) != (sy < 0)) && m != 0) m = m + sy;
          o.value = sext_to(m, vw);
        end
      end
      cia_pkg::OP_AND, cia_pkg::OP_OR: begin
        o.rtype = cia_pkg::TY_BOOL;
        if (xna || yna) o.value = min_of(8);
        else if (sh_op == cia_pkg::OP_AND) o.value = {63'd0, (x != 0 && y != 0)};
        else o.value = {63'd0, (x != 0 || y != 0)};
      end
      default: begin
        o.rtype = cia_pkg::TY_BOOL;
        case (sh_op)
          cia_pkg::OP_EQ: v = (both && sx == sy) || (xna && yna);
          cia_pkg::OP_NE: v = (xna || yna || sx != sy) && !(xna && yna);
          cia_pkg::OP_GT: v = both && sx > sy;
          cia_pkg::OP_LT: v = both && sx < sy;
          cia_pkg::OP_GE: v = (both && sx >= sy) || (xna && yna);
          default:        v = (both && sx <= sy) || (xna && yna);
        endcase
        o.value = {63'd0, v};
      end
    endcase
    return o;
  endfunction

  // valid stays up across back-to-back writes; the next item send drops it
  task automatic write_reg(cia_pkg::cfg_idx_e idx, logic [63:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      cia_pkg::CFG_OP:    sh_op = data[3:0];
      cia_pkg::CFG_LTYPE: sh_lt = data[2:0];
      cia_pkg::CFG_RTYPE: sh_rt = data[2:0];
      cia_pkg::CFG_MODE:  sh_mode = data[1:0];
      default:            sh_scalar = data;
    endcase
  endtask

  task automatic drain;
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (Latency) @(posedge clk_i);
  endtask

  task automatic set_all(logic [3:0] op, logic [2:0] lt, logic [2:0] rt, logic [1:0] mode,
                         logic [63:0] scalar);
    drain();
    write_reg(cia_pkg::CFG_OP, {60'd0, op});
    write_reg(cia_pkg::CFG_LTYPE, {61'd0, lt});
    write_reg(cia_pkg::CFG_RTYPE, {61'd0, rt});
    write_reg(cia_pkg::CFG_MODE, {62'd0, mode});
    write_reg(cia_pkg::CFG_SCALAR, scalar);
  endtask

  // send one operand pair; a known expectation overrides the predictor
  task automatic send_pair(logic [63:0] a, logic [63:0] b, bit known, alu_out_t want);
    cfg_valid_i <= 1'b0;
    if ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {b, a};
    do @(posedge clk_i); while (!s_axis_tready);
    pending_results.push_back(known ? want : column_op(a, b));
  endtask

  function automatic logic [63:0] rand_operand();
    logic [63:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(7))
      0: v = min_of(8 << $urandom_range(3));
      1: v = 64'sd0 - 64'($urandom_range(3));
      2: v = 64'($urandom_range(3));
      3: v = v >> $urandom_range(63);
      default: ;
    endcase
    return v;
  endfunction

  // result side: random backpressure and checking
  always @(posedge clk_i) begin
    alu_out_t got, want;
    if (rst_ni) begin
      cycles <= cycles + 1;
      if (m_axis_tvalid && m_axis_tready) begin
        got = '{value: m_axis_tdata, rtype: m_axis_tuser[2:0], err: m_axis_tuser[3]};
        if (pending_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %h", got);
        end else begin
          want = pending_results.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: value exp %h got %h, type exp %0d got %0d, err exp %b got %b",
                       want.value, got.value, want.rtype, got.rtype, want.err, got.err);
          end
        end
      end
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  initial begin
    vec_t dir[$];
    alu_out_t err_out;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    err_out = '{value: '0, rtype: 3'd0, err: 1'b1};
    // after reset: add, int64
    dir.push_back('{cia_pkg::OP_ADD, cia_pkg::TY_INT64, cia_pkg::TY_INT64, cia_pkg::BC_NONE,
                    64'd5, 64'd7, 1, '{64'd12, cia_pkg::TY_INT64, 1'b0}});
    dir.push_back('{cia_pkg::OP_ADD, cia_pkg::TY_INT64, cia_pkg::TY_INT64, cia_pkg::BC_NONE,
                    64'h7FFF_FFFF_FFFF_FFFF, 64'd1, 1,
                    '{64'h8000_0000_0000_0000, cia_pkg::TY_INT64, 1'b0}});
    dir.push_back('{cia_pkg::OP_ADD, cia_pkg::TY_INT64, cia_pkg::TY_INT64, cia_pkg::BC_NONE,
                    '1, '1, 0, '0});
    dir.push_back('{cia_pkg::OP_SUB, cia_pkg::TY_INT8, cia_pkg::TY_INT16, cia_pkg::BC_NONE,
                    64'h80, 64'd1, 0, '0});
    dir.push_back('{cia_pkg::OP_MUL, cia_pkg::TY_INT32, cia_pkg::TY_INT8, cia_pkg::BC_NONE,
                    64'h7FFF_FFFF, 64'd2, 0, '0});
    dir.push_back('{cia_pkg::OP_FLOORDIV, cia_pkg::TY_INT64, cia_pkg::TY_INT64,
                    cia_pkg::BC_NONE, 64'd7, 64'd0, 1,
                    '{64'h8000_0000_0000_0000, cia_pkg::TY_INT64, 1'b0}});
    dir.push_back('{cia_pkg::OP_FLOORDIV, cia_pkg::TY_INT64, cia_pkg::TY_INT64,
                    cia_pkg::BC_NONE, -64'sd7, 64'd2, 1,
                    '{-64'sd4, cia_pkg::TY_INT64, 1'b0}});
    dir.push_back('{cia_pkg::OP_FLOORDIV, cia_pkg::TY_INT16, cia_pkg::TY_INT16,
                    cia_pkg::BC_NONE, 64'h8001, '1, 0, '0});
    dir.push_back('{cia_pkg::OP_MOD, cia_pkg::TY_INT64, cia_pkg::TY_INT64, cia_pkg::BC_NONE,
                    -64'sd7, 64'd2, 1, '{64'd1, cia_pkg::TY_INT64, 1'b0}});
    dir.push_back('{cia_pkg::OP_MOD, cia_pkg::TY_INT8, cia_pkg::TY_INT8, cia_pkg::BC_NONE,
                    64'd7, -64'sd3, 0, '0});
    dir.push_back('{cia_pkg::OP_EQ, cia_pkg::TY_INT8, cia_pkg::TY_INT8, cia_pkg::BC_NONE,
                    64'h80, 64'h80, 1, '{64'd1, cia_pkg::TY_BOOL, 1'b0}});
    dir.push_back('{cia_pkg::OP_NE, cia_pkg::TY_INT16, cia_pkg::TY_INT32, cia_pkg::BC_NONE,
                    64'h8000, 64'h8000_0000, 0, '0});
    dir.push_back('{cia_pkg::OP_GT, cia_pkg::TY_INT32, cia_pkg::TY_INT64, cia_pkg::BC_NONE,
                    64'd3, 64'd2, 0, '0});
    dir.push_back('{cia_pkg::OP_LT, cia_pkg::TY_BOOL, cia_pkg::TY_BOOL, cia_pkg::BC_NONE,
                    64'hFF, 64'd1, 0, '0});
    dir.push_back('{cia_pkg::OP_GE, cia_pkg::TY_INT64, cia_pkg::TY_INT64, cia_pkg::BC_NONE,
                    64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000, 0, '0});
    dir.push_back('{cia_pkg::OP_LE, cia_pkg::TY_INT8, cia_pkg::TY_INT64, cia_pkg::BC_NONE,
                    64'h80, 64'd0, 0, '0});
    dir.push_back('{cia_pkg::OP_AND, cia_pkg::TY_BOOL, cia_pkg::TY_BOOL, cia_pkg::BC_NONE,
                    64'd2, 64'd1, 1, '{64'd1, cia_pkg::TY_BOOL, 1'b0}});
    dir.push_back('{cia_pkg::OP_OR, cia_pkg::TY_BOOL, cia_pkg::TY_BOOL, cia_pkg::BC_NONE,
                    64'h80, 64'd0, 1, '{64'hFFFF_FFFF_FFFF_FF80, cia_pkg::TY_BOOL, 1'b0}});
    dir.push_back('{cia_pkg::OP_AND, cia_pkg::TY_INT8, cia_pkg::TY_BOOL, cia_pkg::BC_NONE,
                    64'd1, 64'd1, 1, err_out});
    dir.push_back('{4'd13, cia_pkg::TY_INT64, cia_pkg::TY_INT64, cia_pkg::BC_NONE,
                    64'd1, 64'd1, 1, err_out});
    dir.push_back('{cia_pkg::OP_ADD, 3'd5, cia_pkg::TY_INT64, cia_pkg::BC_NONE,
                    64'd1, 64'd1, 1, err_out});
    dir.push_back('{cia_pkg::OP_ADD, cia_pkg::TY_INT64, 3'd7, cia_pkg::BC_NONE,
                    64'd1, 64'd1, 1, err_out});
    dir.push_back('{cia_pkg::OP_ADD, cia_pkg::TY_INT64, cia_pkg::TY_INT64, 2'd3,
                    64'd1, 64'd1, 1, err_out});
    dir.push_back('{cia_pkg::OP_SUB, cia_pkg::TY_INT16, cia_pkg::TY_INT8, cia_pkg::BC_RIGHT,
                    64'd100, 64'd9, 0, '0});
    dir.push_back('{cia_pkg::OP_MUL, cia_pkg::TY_INT8, cia_pkg::TY_INT32, cia_pkg::BC_LEFT,
                    64'd100, 64'd9, 0, '0});
    foreach (dir[i]) begin
      if (i > 2)
        set_all(dir[i].op, dir[i].lt, dir[i].rt, dir[i].mode,
                64'($urandom_range(200)) - 64'd100);
      send_pair(dir[i].a, dir[i].b, dir[i].known, dir[i].want);
    end
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 33 : (phase == 1) ? 71 : 0;
      recv_idle_pct = (phase == 0) ? 71 : (phase == 1) ? 33 : 0;
      for (int blk = 0; blk < 12; blk++) begin
        set_all(($urandom_range(13) == 13) ? 4'hF : 4'($urandom_range(12)),
                3'($urandom_range(4)), 3'($urandom_range(4)),
                ($urandom_range(9) == 0) ? 2'd3 : 2'($urandom_range(2)), rand_operand());
        // logic ops are mostly run on bool columns
        if (sh_op >= cia_pkg::OP_AND && sh_op <= cia_pkg::OP_OR &&
            $urandom_range(3) != 0) begin
          write_reg(cia_pkg::CFG_LTYPE, 64'(cia_pkg::TY_BOOL));
          write_reg(cia_pkg::CFG_RTYPE, 64'(cia_pkg::TY_BOOL));
        end
        for (int k = 0; k < 14; k++) begin
          if (blk == 5 && k == 7) begin
            drain();
          end
          send_pair(rand_operand(), rand_operand(), 0, '0);
        end
      end
    end
    send_idle_pct = 0;
    recv_idle_pct = 0;
    drain();
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("na_aware_integer_column_alu test passed");
    end else begin
      $display("na_aware_integer_column_alu test failed");
    end
    $finish;
  end

  always @(posedge clk_i) begin
    if (cycles > CycleCap) begin
      $display("na_aware_integer_column_alu test failed");
      $finish;
    end
  end

endmodule

// ----- filelist.f -----
rtl/cia_pkg.sv
rtl/cia_front.sv
rtl/cia_prep.sv
rtl/cia_divider.sv
rtl/cia_back.sv
rtl/na_aware_integer_column_alu.sv
rtl/cia_checker.sv
dv/tb_top.sv
